>>> design/brr_pkg.sv
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types and constants of the BRR ADPCM block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package brr_pkg;

  // decoded pcm sample
  typedef logic signed [15:0] brr_sample_t;

  // wide signed word for the predictor sum
  typedef logic signed [20:0] brr_acc_t;

  // byte position within a block: 0 expects the header, 1..8 count data bytes
  typedef logic [3:0] brr_pos_t;

  localparam brr_pos_t    PosHeader         = 4'd0;
  localparam brr_pos_t    PosFirstData      = 4'd1;
  localparam brr_pos_t    DataBytesPerBlock = 4'd8;

  // largest shift range that still scales the nibble
  localparam logic [3:0]  NibbleRangeLimit  = 4'd12;

  // sample forced for a negative nibble when the range is out of bounds
  localparam brr_sample_t NegOutOfRange     = -16'sd2048;

  localparam brr_sample_t SampleMax         = 16'sh7fff;
  localparam brr_sample_t SampleMin         = -16'sh8000;

  // filter select codes
  localparam logic [1:0]  FiltNone          = 2'd0;
  localparam logic [1:0]  FiltOne           = 2'd1;
  localparam logic [1:0]  FiltTwo           = 2'd2;
  localparam logic [1:0]  FiltThree         = 2'd3;

endpackage

`default_nettype wire

>>> design/brr_adpcm_block_decoder_core.sv
// ----------------------------------------------------------------------------
// brr_adpcm_block_decoder_core
// Decodes nine-byte BRR blocks, one byte per word, into 16-bit pcm samples.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] brr_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata[15:0] pcm_sample,
//                                               tlast block_last,
//                                               tuser[2:0] pair_last,
//                                               end_flag, loop_flag
//
//  a data byte is decoded one nibble at a time in the decode stage, since the
//  second sample needs the first as history; a header byte gives no sample.
//  a block of nine bytes thus gives 16 words out.
//  reset clears the byte position, header fields and sample history.
//  an output register holds a finished sample while m_axis stalls; the input
//  register keeps taking a new byte as soon as the held one is fully decoded.
// ----------------------------------------------------------------------------
`default_nettype none

module brr_adpcm_block_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] brr_byte
  // master side
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [15:0] pcm_sample
  output      logic        m_axis_tlast,   // block_last
  output      logic [2:0]  m_axis_tuser    // [0] pair_last, [1] end_flag, [2] loop_flag
);

  // input register and byte position
  brr_pkg::brr_pos_t pos_q;
  brr_pkg::brr_pos_t pos_d;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_hdr_q;
  logic              in_last_q;
  logic              in_accept;
  logic              acc_hdr;

  // header fields
  logic [3:0]        range_q;
  logic [1:0]        filt_q;
  logic [1:0]        endloop_q;

  // decode state
  logic              phase_q;
  brr_pkg::brr_sample_t p1_q;
  brr_pkg::brr_sample_t p2_q;

  // output register
  logic              out_valid_q;
  brr_pkg::brr_sample_t out_sample_q;
  logic              out_last_q;
  logic [2:0]        out_user_q;

  // stage control
  logic              out_free;
  logic              hdr_fire;
  logic              gen_sample;
  logic              in_done;

  // datapath
  logic [3:0]        nib;
  logic signed [3:0] nib_s;
  brr_pkg::brr_acc_t scaled;
  brr_pkg::brr_acc_t p1x;
  brr_pkg::brr_acc_t p2x;
  brr_pkg::brr_acc_t p1x3;
  brr_pkg::brr_acc_t p1x13;
  brr_pkg::brr_acc_t p2x3;
  brr_pkg::brr_acc_t pred;
  brr_pkg::brr_acc_t sum;
  brr_pkg::brr_sample_t sample;

  // handshake and stage control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign hdr_fire      = in_valid_q && in_hdr_q;
  assign gen_sample    = in_valid_q && !in_hdr_q && out_free;
  assign in_done       = hdr_fire || (gen_sample && phase_q);
  assign s_axis_tready = !in_valid_q || in_done;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // byte position at the input; a position past the block counts as a header
  assign acc_hdr = (pos_q == brr_pkg::PosHeader) || (pos_q > brr_pkg::DataBytesPerBlock);

  always_comb begin
    if (acc_hdr) begin
      pos_d = brr_pkg::PosFirstData;
    end else if (pos_q == brr_pkg::DataBytesPerBlock) begin
      pos_d = brr_pkg::PosHeader;
    end else begin
      pos_d = pos_q + 4'd1;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= brr_pkg::PosHeader;
      in_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (in_accept) begin
        pos_q <= pos_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata;
      in_hdr_q  <= acc_hdr;
      in_last_q <= (pos_q == brr_pkg::DataBytesPerBlock);
    end
  end

  // nibble select and scaling by the shift range
  assign nib   = phase_q ? in_byte_q[3:0] : in_byte_q[7:4];
  assign nib_s = $signed(nib);

  always_comb begin
    if (range_q <= brr_pkg::NibbleRangeLimit) begin
      scaled = (brr_pkg::brr_acc_t'(nib_s) <<< range_q) >>> 1;
    end else if (nib_s[3]) begin
      scaled = brr_pkg::brr_acc_t'(brr_pkg::NegOutOfRange);
    end else begin
      scaled = '0;
    end
  end

  // prediction from the two history samples
  assign p1x   = brr_pkg::brr_acc_t'(p1_q);
  assign p2x   = brr_pkg::brr_acc_t'(p2_q);
  assign p1x3  = p1x + (p1x <<< 1);
  assign p1x13 = (p1x <<< 3) + (p1x <<< 2) + p1x;
  assign p2x3  = p2x + (p2x <<< 1);

  always_comb begin
    case (filt_q)
      brr_pkg::FiltNone:  pred = '0;
      brr_pkg::FiltOne:   pred = p1x + ((-p1x) >>> 4);
      brr_pkg::FiltTwo:   pred = (p1x <<< 1) + ((-p1x3) >>> 5) - p2x + (p2x >>> 4);
      brr_pkg::FiltThree: pred = (p1x <<< 1) + ((-p1x13) >>> 6) - p2x + (p2x3 >>> 4);
      default:            pred = '0;
    endcase
  end

  // add and saturate to 16 bits
  assign sum = scaled + pred;

  always_comb begin
    if (sum > brr_pkg::brr_acc_t'(brr_pkg::SampleMax)) begin
      sample = brr_pkg::SampleMax;
    end else if (sum < brr_pkg::brr_acc_t'(brr_pkg::SampleMin)) begin
      sample = brr_pkg::SampleMin;
    end else begin
      sample = sum[15:0];
    end
  end

  // header fields, nibble phase and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q   <= '0;
      filt_q    <= '0;
      endloop_q <= '0;
      phase_q   <= 1'b0;
      p1_q      <= '0;
      p2_q      <= '0;
    end else begin
      if (hdr_fire) begin
        range_q   <= in_byte_q[7:4];
        filt_q    <= in_byte_q[3:2];
        endloop_q <= in_byte_q[1:0];
      end
      if (gen_sample) begin
        phase_q <= !phase_q;
        p2_q    <= p1_q;
        p1_q    <= sample;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= gen_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_sample) begin
      out_sample_q  <= sample;
      out_last_q    <= phase_q && in_last_q;
      out_user_q[0] <= phase_q;
      out_user_q[1] <= phase_q && in_last_q && endloop_q[0];
      out_user_q[2] <= phase_q && in_last_q && endloop_q[1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  a_pos_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= brr_pkg::DataBytesPerBlock)
    else $error("byte position past the block");

  a_phase_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (in_valid_q && !in_hdr_q))
    else $error("second nibble pending without a data byte");

  a_last_is_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
    else $error("block end on a first nibble");

  a_flags_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser[2:1] == 2'b00))
    else $error("end or loop flag away from block end");

endmodule

`default_nettype wire
